### sv/fapu_pkg.sv
// shared types, fixed-point constants and rounding helper for the atan2 unit
package fapu_pkg;

   // internal fixed-point format: signed, 30 fraction bits
   localparam int QF = 30;
   localparam int QW = 33;
   localparam int PW = 2 * QW;

   // ratio format: unsigned Q0.16, quotient carries one integer bit
   localparam int RB = 16;
   localparam int DB = RB + 1;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [PW-1:0] p_type;

   // per-item flags that ride along the pipeline
   typedef struct packed {
      logic undef;
      logic xzero;
      logic xneg;
      logic yneg;
      logic swap;
   } side_type;

   // coefficients, pi and pi/2 in Q.30, rounded to nearest
   localparam longint K_A0_L = (64'sd784086493 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;
   localparam longint K_A1_L = (64'sd243049811 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;
   localparam longint K_A2_L = (64'sd76784963 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;
   localparam longint K_B0_L = (64'sd785534552 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;
   localparam longint K_B1_L = (64'sd217350373 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;
   localparam longint K_B2_L = -((64'sd139301583 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000);
   localparam longint K_B3_L = -((64'sd1449231561 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000);
   localparam longint K_PI_L = (64'sd3141592654 * 64'sd1073741824 + 64'sd500000000)
                               / 64'sd1000000000;

   localparam q_type K_A0    = q_type'(K_A0_L);
   localparam q_type K_A1    = q_type'(K_A1_L);
   localparam q_type K_A2    = q_type'(K_A2_L);
   localparam q_type K_B0    = q_type'(K_B0_L);
   localparam q_type K_B1    = q_type'(K_B1_L);
   localparam q_type K_B2    = q_type'(K_B2_L);
   localparam q_type K_B3    = q_type'(K_B3_L);
   localparam q_type K_PI    = q_type'(K_PI_L);
   localparam q_type K_HPI   = q_type'(K_PI_L / 64'sd2);
   localparam q_type Q_ONE   = q_type'(64'sd1 << QF);

   localparam logic [PW-1:0] RND_HALF = PW'(64'd1 << (QF - 1));

   // product back to Q.30, half away from zero
   function automatic q_type rnd_q30(input p_type p);
      logic [PW-1:0] mag;
      logic [PW-1:0] sh;
      mag = p[PW-1] ? PW'(-p) : PW'(p);
      sh  = (mag + RND_HALF) >> QF;
      rnd_q30 = p[PW-1] ? -q_type'(sh[QW-1:0]) : q_type'(sh[QW-1:0]);
   endfunction

endpackage

### sv/fapu_if.sv
// valid/ready channel interfaces for request, response and register write

interface fapu_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] y_coord;
   logic signed [COORD_WIDTH-1:0] x_coord;
   modport source (output valid, y_coord, x_coord, input ready);
   modport sink   (input valid, y_coord, x_coord, output ready);
endinterface

interface fapu_rsp_if #(parameter int ANGLE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] angle;
   logic                          undefined;
   modport source (output valid, angle, undefined, input ready);
   modport sink   (input valid, angle, undefined, output ready);
endinterface

interface fapu_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### sv/fapu_div.sv
// pipelined restoring divider, one quotient bit per stage
module fapu_div #(
   parameter int W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [W+fapu_pkg::DB-1:0] num,
   input  logic [W-1:0]          den,
   input  fapu_pkg::side_type    side_in,
   output logic                  out_vld,
   output logic [fapu_pkg::DB-1:0] quo,
   output fapu_pkg::side_type    side_out
);
   import fapu_pkg::*;

   logic           vld_ff  [0:DB];
   logic [W-1:0]   rem_ff  [0:DB];
   logic [DB-1:0]  low_ff  [0:DB];
   logic [DB-1:0]  quo_ff  [0:DB];
   logic [W-1:0]   den_ff  [0:DB];
   side_type       side_ff [0:DB];

   // load stage: top bits of the dividend are already below the divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
      if (en) begin
         rem_ff[0]  <= num[W+DB-1:DB];
         low_ff[0]  <= num[DB-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= den;
         side_ff[0] <= side_in;
      end
   end

   // one shift-compare-subtract per stage
   for (genvar k = 1; k <= DB; k++) begin : g_step
      logic [W:0] trial;
      logic       ge;
      always_comb begin
         trial = {rem_ff[k-1], low_ff[k-1][DB-k]};
         ge    = trial >= {1'b0, den_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= ge ? W'(trial - {1'b0, den_ff[k-1]}) : W'(trial);
            low_ff[k]  <= low_ff[k-1];
            quo_ff[k]  <= {quo_ff[k-1][DB-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[DB];
   assign quo      = quo_ff[DB];
   assign side_out = side_ff[DB];

endmodule

### sv/fapu_poly.sv
// first-octant minimax polynomial, one multiply or one round-and-add per stage
module fapu_poly (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    mode,
   input  logic                    in_vld,
   input  logic [fapu_pkg::DB-1:0] ratio,
   input  fapu_pkg::side_type      side_in,
   output logic                    out_vld,
   output fapu_pkg::q_type         octant,
   output fapu_pkg::side_type      side_out
);
   import fapu_pkg::*;

   localparam int NS = 9;

   logic     vld_ff  [1:NS];
   side_type side_ff [1:NS];

   q_type z1_ff, s1_ff, z2_ff, z3_ff, v3_ff, z4_ff, v4_ff;
   q_type z5_ff, t5_ff, zm5_ff, z6_ff, z7_ff, u7_ff, a9_ff;
   p_type p2_ff, p4_ff, p6_ff, p8_ff;
   q_type z_in;

   // ratio to Q.30
   assign z_in = q_type'({{(QW-DB-(QF-RB)){1'b0}}, ratio, {(QF-RB){1'b0}}});

   // valid bits and side flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NS; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= in_vld;
         for (int i = 2; i <= NS; i++) vld_ff[i] <= vld_ff[i-1];
      end
      if (en) begin
         side_ff[1] <= side_in;
         for (int i = 2; i <= NS; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (en) begin
         // z and b3 + z
         z1_ff <= z_in;
         s1_ff <= K_B3 + z_in;
         // first product
         p2_ff <= mode ? z1_ff * s1_ff : K_A2 * z1_ff;
         z2_ff <= z1_ff;
         // round
         v3_ff <= rnd_q30(p2_ff);
         z3_ff <= z2_ff;
         // b2 times inner term
         p4_ff <= K_B2 * v3_ff;
         v4_ff <= v3_ff;
         z4_ff <= z3_ff;
         // t and z - 1
         t5_ff  <= mode ? K_B1 + rnd_q30(p4_ff) : K_A1 + v4_ff;
         zm5_ff <= z4_ff - Q_ONE;
         z5_ff  <= z4_ff;
         // (z - 1) * t
         p6_ff <= zm5_ff * t5_ff;
         z6_ff <= z5_ff;
         // leading coefficient minus product
         u7_ff <= (mode ? K_B0 : K_A0) - rnd_q30(p6_ff);
         z7_ff <= z6_ff;
         // z * u
         p8_ff <= z7_ff * u7_ff;
         // final round
         a9_ff <= rnd_q30(p8_ff);
      end
   end

   assign out_vld  = vld_ff[NS];
   assign octant   = a9_ff;
   assign side_out = side_ff[NS];

endmodule

### sv/fast_atan2_polynomial_unit.sv
// Four-quadrant arctangent of a signed (y, x) pair, result in signed Q3.ANGLE_FRAC_BITS
// radians. A new pair is taken every clock; each result passes through 32 register stages:
// input capture, magnitude and min/max with the rounded dividend, 18 divider stages (load
// plus one per quotient bit), nine stages of polynomial multiply and round, then the
// reflect, quadrant and output stages. Backpressure on the response stalls the whole
// pipeline without losing beats.
// poly_mode selects the three- (0) or four-coefficient (1) polynomial; write it only
// while the unit is empty.
module fast_atan2_polynomial_unit #(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic       clock,
   input  logic       reset,
   fapu_req_if.sink   req_ch,
   fapu_rsp_if.source rsp_ch,
   fapu_csr_if.sink   csr_ch
);
   import fapu_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam int SH = QF - ANGLE_FRAC_BITS;
   localparam logic [QW-1:0] A_HALF = QW'(64'd1 << (SH - 1));

   logic en;
   logic mode_ff;

   logic                vld0_ff;
   logic signed [W-1:0] y0_ff, x0_ff;

   logic [W-1:0]        ax, ay, mn, mx;
   side_type            side1_in;
   logic                vld1_ff;
   logic [W+DB-1:0]     num1_ff;
   logic [W-1:0]        den1_ff;
   side_type            side1_ff;

   logic                dvld;
   logic [DB-1:0]       dquo;
   side_type            dside;

   logic                pvld;
   q_type               poct;
   side_type            pside;

   logic                vldf1_ff;
   q_type               refl_ff;
   side_type            sidef1_ff;

   logic                vldf2_ff;
   q_type               ang_ff;
   logic                undf2_ff;
   q_type               ang_in;

   logic                out_vld_ff;
   logic signed [AW-1:0] angle_ff;
   logic                undef_ff;
   logic [QW-1:0]       amag, arnd;
   logic signed [AW-1:0] angle_in;

   // pipeline advances unless a result waits on a stalled output
   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // mode register
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         mode_ff <= csr_ch.data;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= req_ch.valid;
      end
      if (en) begin
         y0_ff <= req_ch.y_coord;
         x0_ff <= req_ch.x_coord;
      end
   end

   // magnitudes, min/max and rounded dividend
   always_comb begin
      ax = x0_ff[W-1] ? W'(-x0_ff) : W'(x0_ff);
      ay = y0_ff[W-1] ? W'(-y0_ff) : W'(y0_ff);
      mn = (ax < ay) ? ax : ay;
      mx = (ax < ay) ? ay : ax;
      side1_in.xzero = (x0_ff == '0);
      side1_in.undef = (x0_ff == '0) && (y0_ff == '0);
      side1_in.xneg  = x0_ff[W-1];
      side1_in.yneg  = y0_ff[W-1];
      side1_in.swap  = ay > ax;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld0_ff;
      end
      if (en) begin
         num1_ff  <= {1'b0, mn, {RB{1'b0}}} + (W+DB)'(mx >> 1);
         den1_ff  <= mx;
         side1_ff <= side1_in;
      end
   end

   fapu_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld1_ff),
      .num      (num1_ff),
      .den      (den1_ff),
      .side_in  (side1_ff),
      .out_vld  (dvld),
      .quo      (dquo),
      .side_out (dside)
   );

   fapu_poly u_poly (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .mode     (mode_ff),
      .in_vld   (dvld),
      .ratio    (dquo),
      .side_in  (dside),
      .out_vld  (pvld),
      .octant   (poct),
      .side_out (pside)
   );

   // reflect through pi/2 when |y| > |x|
   always_ff @(posedge clock) begin
      if (reset) begin
         vldf1_ff <= 1'b0;
      end else if (en) begin
         vldf1_ff <= pvld;
      end
      if (en) begin
         refl_ff   <= pside.swap ? K_HPI - poct : poct;
         sidef1_ff <= pside;
      end
   end

   // quadrant fix and x-zero cases
   always_comb begin
      priority if (sidef1_ff.undef) begin
         ang_in = '0;
      end else if (sidef1_ff.xzero) begin
         ang_in = sidef1_ff.yneg ? -K_HPI : K_HPI;
      end else if (!sidef1_ff.xneg) begin
         ang_in = sidef1_ff.yneg ? -refl_ff : refl_ff;
      end else begin
         ang_in = sidef1_ff.yneg ? refl_ff - K_PI : K_PI - refl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldf2_ff <= 1'b0;
      end else if (en) begin
         vldf2_ff <= vldf1_ff;
      end
      if (en) begin
         ang_ff   <= ang_in;
         undf2_ff <= sidef1_ff.undef;
      end
   end

   // round to output precision, half away from zero
   always_comb begin
      amag     = ang_ff[QW-1] ? QW'(-ang_ff) : QW'(ang_ff);
      arnd     = (amag + A_HALF) >> SH;
      angle_in = ang_ff[QW-1] ? -AW'(arnd) : AW'(arnd);
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vldf2_ff;
      end
      if (en) begin
         angle_ff <= angle_in;
         undef_ff <= undf2_ff;
      end
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.angle     = angle_ff;
   assign rsp_ch.undefined = undef_ff;

endmodule

### bench/tb_fapu_if_note.sv
`timescale 1ns / 1ps
// bench-side channel helpers: none needed beyond the rtl interfaces
package tb_fapu_util_pkg;
   localparam int LAT = 32;
endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the atan2 polynomial unit
module tb_top;
   import fapu_pkg::*;
   import tb_fapu_util_pkg::*;

   // golden angle computation in Q.30 then Q3.13
   class atan2_scoreboard;
      bit mode;
      logic [15:0] exp_angle[$];
      bit exp_undef[$];
      int errors;
      int checked;

      function longint rshift(longint v, int s);
         longint h;
         h = longint'(1) << (s - 1);
         if (v < 0) return -((-v + h) >>> s);
         return (v + h) >>> s;
      endfunction

      function longint qm(longint a, longint b);
         return rshift(a * b, 30);
      endfunction

      function longint octant(longint z);
         longint t;
         if (mode) begin
            t = K_B1_L + qm(K_B2_L, qm(z, K_B3_L + z));
            return qm(z, K_B0_L - qm(z - (longint'(1) << 30), t));
         end
         t = K_A1_L + qm(K_A2_L, z);
         return qm(z, K_A0_L - qm(z - (longint'(1) << 30), t));
      endfunction

      function void note_pair(logic signed [15:0] yv, logic signed [15:0] xv);
         longint y, x, ay, ax, mn, mx, r, a, ang, hpi;
         bit u;
         y = longint'(yv); x = longint'(xv); u = 1'b0;
         ay = y < 0 ? -y : y;
         ax = x < 0 ? -x : x;
         hpi = K_PI_L / 2;
         if (x == 0) begin
            if (y > 0) ang = hpi;
            else if (y < 0) ang = -hpi;
            else begin
               ang = 0; u = 1'b1;
            end
         end else begin
            mn = ax < ay ? ax : ay;
            mx = ax < ay ? ay : ax;
            r = ((mn << 16) + (mx >> 1)) / mx;
            a = octant(r << 14);
            if (ay > ax) a = hpi - a;
            if (x > 0) ang = (y < 0) ? -a : a;
            else if (y >= 0) ang = K_PI_L - a;
            else ang = a - K_PI_L;
         end
         ang = rshift(ang, 17);
         exp_angle.push_back(ang[15:0]);
         exp_undef.push_back(u);
      endfunction

      function void check_result(logic [15:0] ang, logic u);
         logic [15:0] ea;
         bit eu;
         if (exp_angle.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result angle=%0d", $signed(ang));
            return;
         end
         ea = exp_angle.pop_front();
         eu = exp_undef.pop_front();
         checked++;
         if (ea !== ang || eu !== u) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected angle=%0d undef=%0b, got angle=%0d undef=%0b",
                        $signed(ea), eu, $signed(ang), u);
         end
      endfunction
   endclass

   logic clock, reset;
   fapu_req_if #(16) req_ch();
   fapu_rsp_if #(16) rsp_ch();
   fapu_csr_if csr_ch();

   fast_atan2_polynomial_unit uut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   atan2_scoreboard sb;
   bit quiet_tail;
   bit hold_long;
   int idle_cycles;
   int sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // drive one coordinate pair, with random gaps before it
   task automatic send_pair(logic signed [15:0] yv, logic signed [15:0] xv);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.y_coord <= yv;
      req_ch.x_coord <= xv;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pair(yv, xv);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.exp_angle.size() != 0) @(posedge clock);
      repeat (LAT + 8) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= m;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.mode = m;
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
         default: return 16'($urandom);
      endcase
   endfunction

   // result sink with random stalls and one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.angle, rsp_ch.undefined);
         rsp_ch.ready <= hold_long ? 1'b0 :
                         (quiet_tail ? 1'b1 : ($urandom_range(0, 5) != 0));
      end
   end

   // watchdog on cycles with no beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog: no beats accepted");
         $display("FAILED: results differ");
         $finish;
      end
   end

   // stimulus
   initial begin
      sb = new();
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.y_coord = '0; req_ch.x_coord = '0;
      csr_ch.valid = 1'b0; csr_ch.data = 1'b0;
      quiet_tail = 1'b0; hold_long = 1'b0; sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int m = 0; m < 2; m++) begin
         write_mode(1'(m));
         // directed corners: zeros, axes, equal magnitudes, extremes
         send_pair(16'sd0, 16'sd0);
         send_pair(16'sd5, 16'sd0);
         send_pair(-16'sd5, 16'sd0);
         send_pair(16'sd0, -16'sd7);
         send_pair(16'sd0, 16'sd7);
         send_pair(16'sh7fff, 16'sh7fff);
         send_pair(-16'sd100, 16'sd100);
         send_pair(16'sd100, -16'sd100);
         send_pair(-16'sd100, -16'sd100);
         send_pair(16'sh8000, 16'sh8000);
         send_pair(16'sh8000, 16'sh7fff);
         send_pair(16'sh7fff, 16'sh8000);
         send_pair(16'sh8000, 16'sd0);
         send_pair(16'sd0, 16'sh8000);
         send_pair(16'sd1, 16'sh7fff);
         send_pair(16'sh7fff, -16'sd1);
         drain();
      end
      // random phases across mode settings
      for (int ph = 0; ph < 6; ph++) begin
         write_mode(1'($urandom_range(0, 1)));
         if (ph == 5) quiet_tail = 1'b1;
         for (int i = 0; i < 170; i++) begin
            if (ph == 2 && i == 20) fork
               begin
                  hold_long = 1'b1;
                  repeat (80) @(posedge clock);
                  hold_long = 1'b0;
               end
            join_none
            send_pair(rand_coord(), rand_coord());
         end
         drain();
      end
      $display("covered %0d pairs over both polynomial modes, %0d results checked",
               sent, sb.checked);
      if (sb.errors == 0 && sb.exp_angle.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
